>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the mailbox FIFO unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge while out of reset.
`define ASSERT_SYNC(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Check on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> src/mmf_pkg.sv
// ---------------------------------------------------------------------------
// mmf_pkg
// Shared widths, codes, types and helpers of the message mailbox FIFO.
// ---------------------------------------------------------------------------
package mmf_pkg;

    localparam int SLOTS_DEF      = 8;
    localparam int MSG_BYTES_DEF  = 256;
    localparam int DATA_W         = 64;
    localparam int LEN_W          = 9;
    localparam int BCNT_W         = 4;
    localparam int BYTES_PER_WORD = 8;

    localparam logic KIND_SEND = 1'b0;
    localparam logic KIND_RECV = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic wr_en;
        logic commit;
        logic done;
        logic dropped;
    } send_op_t;

    function automatic logic [DATA_W-1:0] byte_mask(input logic [BCNT_W-1:0] nbytes);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < BYTES_PER_WORD; i++) begin
            m[8*i +: 8] = (BCNT_W'(i) < nbytes) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

>>> src/mmf_ram.sv
// ---------------------------------------------------------------------------
// mmf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module mmf_ram #(
    parameter int DATA_W = mmf_pkg::DATA_W,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/mmf_send.sv
// ---------------------------------------------------------------------------
// mmf_send
// Send-side tracker: byte count, drop flag and store write of each word.
// ---------------------------------------------------------------------------
module mmf_send #(
    parameter int MSG_BYTES = mmf_pkg::MSG_BYTES_DEF,
    localparam int WPS      = (MSG_BYTES + 7) / 8,
    localparam int WIDX_W   = (WPS > 1) ? $clog2(WPS) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         fire,
    input  logic                         last_word,
    input  logic [mmf_pkg::DATA_W-1:0]   data_word,
    input  logic [mmf_pkg::BCNT_W-1:0]   byte_count,
    input  logic                         queue_full,
    output mmf_pkg::send_op_t            op,
    output logic [WIDX_W-1:0]            wr_idx,
    output logic [mmf_pkg::DATA_W-1:0]   wr_data,
    output logic [mmf_pkg::LEN_W-1:0]    length
);

    import mmf_pkg::*;

    logic [LEN_W-1:0]  bytes_reg;
    logic              dropping_reg;
    logic              drop;
    logic [BCNT_W-1:0] nb;
    logic [BCNT_W-1:0] take;
    logic [LEN_W-1:0]  room;
    logic              store;
    logic [LEN_W-1:0]  len_next;

    always_comb begin
        drop = dropping_reg || ((bytes_reg == '0) && queue_full);
        if (!last_word || (byte_count > BCNT_W'(BYTES_PER_WORD))) begin
            nb = BCNT_W'(BYTES_PER_WORD);
        end else begin
            nb = byte_count;
        end
        room  = LEN_W'(MSG_BYTES) - bytes_reg;
        take  = (LEN_W'(nb) < room) ? nb : room[BCNT_W-1:0];
        store = !drop && (bytes_reg < LEN_W'(MSG_BYTES)) && (nb != '0);
        len_next = store ? (bytes_reg + LEN_W'(take)) : bytes_reg;
    end

    assign wr_idx     = bytes_reg[3 +: WIDX_W];
    assign wr_data    = data_word & byte_mask(take);
    assign length     = len_next;
    assign op.wr_en   = fire && store;
    assign op.commit  = fire && last_word && !drop;
    assign op.done    = fire && last_word;
    assign op.dropped = drop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_reg    <= '0;
            dropping_reg <= 1'b0;
        end else if (fire) begin
            if (last_word) begin
                bytes_reg    <= '0;
                dropping_reg <= 1'b0;
            end else begin
                bytes_reg    <= len_next;
                dropping_reg <= drop;
            end
        end
    end

endmodule

>>> src/message_mailbox_fifo_unit.sv
// ---------------------------------------------------------------------------
// message_mailbox_fifo_unit
// Mailbox FIFO of variable-length messages held in a ring of RAM slots.
// ---------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// s_       in   s_valid/s_ready    kind, data_word, byte_count, last_word, max_len
// m_       out  m_valid/m_ready    result_kind, status, out_word, out_bytes,
//                                  msg_length, last_result
//
// A send word is handled as it is accepted; the last one loads its status item at once.
// A receive steps through accept, slot length read, then one word a cycle
// while m_ is not stalled, from the single read port of the message RAM.
// Reset clears pointers, count and send state; RAMs are not cleared.
// A stall on m_ holds the output register and pauses the word stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module message_mailbox_fifo_unit #(
    parameter int SLOTS     = mmf_pkg::SLOTS_DEF,
    parameter int MSG_BYTES = mmf_pkg::MSG_BYTES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic [mmf_pkg::DATA_W-1:0]   s_data_word,
    input  logic [mmf_pkg::BCNT_W-1:0]   s_byte_count,
    input  logic                         s_last_word,
    input  logic [mmf_pkg::LEN_W-1:0]    s_max_len,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_result_kind,
    output logic [1:0]                   m_status,
    output logic [mmf_pkg::DATA_W-1:0]   m_out_word,
    output logic [mmf_pkg::BCNT_W-1:0]   m_out_bytes,
    output logic [mmf_pkg::LEN_W-1:0]    m_msg_length,
    output logic                         m_last_result
);

    import mmf_pkg::*;

    localparam int WPS    = (MSG_BYTES + 7) / 8;
    localparam int WIDX_W = (WPS > 1) ? $clog2(WPS) : 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int ADDR_W = SLOT_W + WIDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_DATA
    } state_t;

    state_t             state_reg;
    logic [SLOT_W-1:0]  head_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [LEN_W-1:0]   maxl_reg;
    logic [WIDX_W-1:0]  widx_reg;
    logic [LEN_W-1:0]   n_reg;
    logic [LEN_W-1:0]   left_reg;

    logic               m_valid_reg;
    logic               m_result_kind_reg;
    logic [1:0]         m_status_reg;
    logic [DATA_W-1:0]  m_out_word_reg;
    logic [BCNT_W-1:0]  m_out_bytes_reg;
    logic [LEN_W-1:0]   m_msg_length_reg;
    logic               m_last_result_reg;

    logic               out_free;
    logic               out_load;
    logic               in_fire;
    logic               send_fire;
    logic               recv_fire;
    logic               recv_start;
    logic               data_emit;
    logic               data_last;
    logic [BCNT_W-1:0]  data_nb;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [LEN_W-1:0]   len_pick;
    logic [SLOT_W:0]    tail_sum;
    logic [SLOT_W-1:0]  tail;
    logic [SLOT_W-1:0]  head_next;
    logic               queue_full;

    send_op_t           send_op;
    logic [WIDX_W-1:0]  send_idx;
    logic [DATA_W-1:0]  send_data;
    logic [LEN_W-1:0]   send_len;
    logic [DATA_W-1:0]  word_rd;
    logic [LEN_W-1:0]   len_rd;

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == S_IDLE) && out_free;
    assign queue_full = (count_reg == CNT_W'(SLOTS));
    assign tail_sum   = {1'b0, head_reg} + (SLOT_W + 1)'(count_reg);
    assign tail       = (tail_sum >= (SLOT_W + 1)'(SLOTS))
                      ? SLOT_W'(tail_sum - (SLOT_W + 1)'(SLOTS)) : tail_sum[SLOT_W-1:0];
    assign head_next  = (head_reg == SLOT_W'(SLOTS - 1)) ? '0 : head_reg + SLOT_W'(1);

    always_comb begin
        in_fire    = s_valid && s_ready;
        send_fire  = in_fire && (s_kind == KIND_SEND);
        recv_fire  = in_fire && (s_kind == KIND_RECV);
        recv_start = recv_fire && (count_reg != '0);
        data_last  = (left_reg <= LEN_W'(BYTES_PER_WORD));
        data_nb    = data_last ? left_reg[BCNT_W-1:0] : BCNT_W'(BYTES_PER_WORD);
        data_emit  = (state_reg == S_DATA) && out_free;
        rd_en      = recv_start || (data_emit && !data_last);
        rd_addr    = recv_start ? {head_reg, WIDX_W'(0)}
                                : {slot_reg, widx_reg + WIDX_W'(1)};
        len_pick   = (len_rd < maxl_reg) ? len_rd : maxl_reg;
        out_load   = ((state_reg == S_IDLE)
                      && (send_op.done || (recv_fire && (count_reg == '0))))
                   || ((state_reg == S_LEN) && (len_pick == '0) && out_free)
                   || data_emit;
    end

    mmf_send #(
        .MSG_BYTES (MSG_BYTES)
    ) u_send (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (send_fire),
        .last_word  (s_last_word),
        .data_word  (s_data_word),
        .byte_count (s_byte_count),
        .queue_full (queue_full),
        .op         (send_op),
        .wr_idx     (send_idx),
        .wr_data    (send_data),
        .length     (send_len)
    );

    mmf_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_word_ram (
        .aclk    (aclk),
        .wr_en   (send_op.wr_en),
        .wr_addr ({tail, send_idx}),
        .wr_data (send_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (word_rd)
    );

    mmf_ram #(
        .DATA_W (LEN_W),
        .ADDR_W (SLOT_W)
    ) u_len_ram (
        .aclk    (aclk),
        .wr_en   (send_op.commit),
        .wr_addr (tail),
        .wr_data (send_len),
        .rd_en   (recv_start),
        .rd_addr (head_reg),
        .rd_data (len_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            head_reg    <= '0;
            count_reg   <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (send_op.done) begin
                        m_result_kind_reg <= KIND_SEND;
                        m_status_reg      <= send_op.dropped ? STATUS_FULL : STATUS_OK;
                        m_out_word_reg    <= '0;
                        m_out_bytes_reg   <= '0;
                        m_msg_length_reg  <= send_op.dropped ? '0 : send_len;
                        m_last_result_reg <= 1'b1;
                    end
                    if (send_op.commit) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    if (recv_fire && (count_reg == '0)) begin
                        m_result_kind_reg <= KIND_RECV;
                        m_status_reg      <= STATUS_EMPTY;
                        m_out_word_reg    <= '0;
                        m_out_bytes_reg   <= '0;
                        m_msg_length_reg  <= '0;
                        m_last_result_reg <= 1'b1;
                    end
                    if (recv_start) begin
                        slot_reg  <= head_reg;
                        maxl_reg  <= s_max_len;
                        widx_reg  <= '0;
                        head_reg  <= head_next;
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= S_LEN;
                    end
                end
                S_LEN: begin
                    n_reg    <= len_pick;
                    left_reg <= len_pick;
                    if (len_pick != '0) begin
                        state_reg <= S_DATA;
                    end else if (out_free) begin
                        m_result_kind_reg <= KIND_RECV;
                        m_status_reg      <= STATUS_OK;
                        m_out_word_reg    <= '0;
                        m_out_bytes_reg   <= '0;
                        m_msg_length_reg  <= '0;
                        m_last_result_reg <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                S_DATA: begin
                    if (data_emit) begin
                        m_result_kind_reg <= KIND_RECV;
                        m_status_reg      <= STATUS_OK;
                        m_out_word_reg    <= word_rd & byte_mask(data_nb);
                        m_out_bytes_reg   <= data_nb;
                        m_msg_length_reg  <= n_reg;
                        m_last_result_reg <= data_last;
                        if (data_last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            left_reg <= left_reg - LEN_W'(BYTES_PER_WORD);
                            widx_reg <= widx_reg + WIDX_W'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_result_kind_reg;
    assign m_status      = m_status_reg;
    assign m_out_word    = m_out_word_reg;
    assign m_out_bytes   = m_out_bytes_reg;
    assign m_msg_length  = m_msg_length_reg;
    assign m_last_result = m_last_result_reg;

    `ASSERT_SYNC(a_count_range, aclk, aresetn, count_reg <= CNT_W'(SLOTS))
    `ASSERT_SYNC(a_data_nonempty, aclk, aresetn, (state_reg == S_DATA) |-> (left_reg != '0))
    `ASSERT_SYNC(a_empty_recv_keeps, aclk, aresetn, (recv_fire && (count_reg == '0)) |=> ((count_reg == '0) && (state_reg == S_IDLE)))
    `ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> (!m_valid && (state_reg == S_IDLE)))

endmodule
